[rtl/core/positional_list_engine_unit_defines.svh]
// Assertion macros shared by the list engine RTL.
// Each macro checks a property on the rising edge of the given clock.
`ifndef POSITIONAL_LIST_ENGINE_UNIT_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_DEFINES_SVH

`ifndef SYNTH
// Checked only while the active-low reset is released.
`define PLEU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("pleu assertion failed");
// Checked on every edge, reset included.
`define PLEU_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("pleu assertion failed");
`else
`define PLEU_ASSERT(lbl, clk, rstn, prop)
`define PLEU_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[rtl/core/pleu_pkg.sv]
`default_nettype none

package pleu_pkg;

  // Fixed field widths of the list engine.
  localparam int unsigned PosW  = 7;
  localparam int unsigned DataW = 32;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_SEARCH = 3'd2,
    OP_COUNT  = 3'd3,
    OP_DUMP   = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_BADPOS  = 3'd2,
    ST_FULL    = 3'd3,
    ST_MISSING = 3'd4
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } state_e;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic                    ins_en;
    logic                    del_en;
    logic                    rot_en;
    logic [PosW-1:0]         slot;
    logic [PosW-1:0]         count;
    logic signed [DataW-1:0] new_value;
  } cell_ctl_t;

endpackage

`default_nettype wire

[rtl/core/pleu_cell.sv]
`default_nettype none

module pleu_cell
  import pleu_pkg::*;
#(
  parameter int unsigned Index = 0
) (
  input  wire logic                    clk_i,
  input  wire cell_ctl_t               ctl_i,
  input  wire logic signed [DataW-1:0] left_i,
  input  wire logic signed [DataW-1:0] right_i,
  input  wire logic signed [DataW-1:0] head_i,
  output logic signed [DataW-1:0]      value_o,
  output logic                         match_o
);

  localparam logic [PosW-1:0] IdxPos  = PosW'(Index);
  localparam logic [PosW-1:0] NextPos = PosW'(Index + 1);

  logic signed [DataW-1:0] value_q, value_d;

  // Pick the new content: shift right on insert, left on delete, rotate on dump.
  always_comb begin
    value_d = value_q;
    if (ctl_i.ins_en) begin
      if (IdxPos > ctl_i.slot) begin
        value_d = left_i;
      end else if (IdxPos == ctl_i.slot) begin
        value_d = ctl_i.new_value;
      end
    end else if (ctl_i.del_en) begin
      if ((IdxPos >= ctl_i.slot) && (NextPos < ctl_i.count)) begin
        value_d = right_i;
      end
    end else if (ctl_i.rot_en) begin
      if (NextPos < ctl_i.count) begin
        value_d = right_i;
      end else if (NextPos == ctl_i.count) begin
        value_d = head_i;
      end
    end
  end

  // Entry storage has no reset; only occupied cells are ever read.
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign match_o = (IdxPos < ctl_i.count) && (value_q == ctl_i.new_value);

endmodule

`default_nettype wire

[rtl/core/positional_list_engine_unit.sv]
// Edits, search and count: one item per cycle unless stalled; result registered at transfer.
// Dump of n entries: the item is taken, then one entry per cycle unless the output stalls.
// The input stalls during a dump; the chain of cells rotates by one entry per result.
// Reset (rst_ni low, asynchronous) empties the list and clears the output valid flag.
// Entry cells are not reset; an entry is read only after it has been written.
`default_nettype none
`include "positional_list_engine_unit_defines.svh"

module positional_list_engine_unit
  import pleu_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [2:0]              opcode_i,
  input  wire logic [PosW-1:0]         position_i,
  input  wire logic signed [DataW-1:0] item_value_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [2:0]                   status_o,
  output logic [PosW-1:0]              found_position_o,
  output logic signed [DataW-1:0]      entry_value_o,
  output logic [PosW-1:0]              length_o,
  output logic                         last_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  state_e                  state_q, state_d;
  logic [CntW-1:0]         count_q, count_d;
  logic [CntW-1:0]         dump_idx_q, dump_idx_d;
  logic                    out_valid_q, out_valid_d;
  logic [2:0]              status_q;
  logic [PosW-1:0]         fpos_q;
  logic signed [DataW-1:0] evalue_q;
  logic [PosW-1:0]         len_q;
  logic                    last_q;

  cell_ctl_t               ctl;
  logic                    load_ok, in_fire;
  logic                    res_load, res_last;
  status_e                 res_status;
  logic [PosW-1:0]         res_fpos;
  logic signed [DataW-1:0] res_value;
  logic [PosW-1:0]         cnt_pos, dump_pos;
  logic                    dump_last;
  logic                    list_full, list_empty;
  logic                    hit;
  logic [PosW-1:0]         hit_pos;

  logic signed [DataW-1:0] cell_value [DEPTH];
  logic [DEPTH-1:0]        cell_match;

  // Handshake: a new result may load when the output register is free or draining.
  assign load_ok    = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !load_ok;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign cnt_pos    = PosW'(count_q);
  assign dump_pos   = PosW'(dump_idx_q) + PosW'(1);
  assign dump_last  = (dump_pos == cnt_pos);
  assign list_full  = (count_q == CntW'(DEPTH));
  assign list_empty = (count_q == '0);

  // Chain of cells; each cell sees its two neighbors and the head for rotation.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DataW-1:0] left_val, right_val;
    if (g == 0) begin : g_head
      assign left_val = ctl.new_value;
    end else begin : g_body
      assign left_val = cell_value[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign right_val = '0;
    end else begin : g_inner
      assign right_val = cell_value[g+1];
    end
    pleu_cell #(
      .Index(g)
    ) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .left_i (left_val),
      .right_i(right_val),
      .head_i (cell_value[0]),
      .value_o(cell_value[g]),
      .match_o(cell_match[g])
    );
  end

  // Lowest matching cell gives the search position.
  always_comb begin
    hit     = 1'b0;
    hit_pos = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (cell_match[i]) begin
        hit     = 1'b1;
        hit_pos = PosW'(i + 1);
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && (opcode_i == OP_DUMP) && !list_empty) begin
          state_d = S_DUMP;
        end
      end
      S_DUMP: begin
        if (load_ok && dump_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Operation decode, cell control and result formation.
  always_comb begin
    ctl.ins_en    = 1'b0;
    ctl.del_en    = 1'b0;
    ctl.rot_en    = 1'b0;
    ctl.slot      = '0;
    ctl.count     = cnt_pos;
    ctl.new_value = item_value_i;
    res_load      = 1'b0;
    res_status    = ST_OK;
    res_fpos      = '0;
    res_value     = '0;
    res_last      = 1'b1;
    count_d       = count_q;
    dump_idx_d    = dump_idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          res_load = 1'b1;
          unique case (op_e'(opcode_i))
            OP_INSERT: begin
              if (list_full) begin
                res_status = ST_FULL;
              end else if (list_empty) begin
                ctl.ins_en = 1'b1;
                count_d    = count_q + CntW'(1);
              end else if (position_i == '0) begin
                res_status = ST_BADPOS;
              end else begin
                ctl.ins_en = 1'b1;
                ctl.slot   = (position_i > cnt_pos) ? cnt_pos : (position_i - PosW'(1));
                count_d    = count_q + CntW'(1);
              end
            end
            OP_DELETE: begin
              if (list_empty) begin
                res_status = ST_EMPTY;
              end else if ((position_i == '0) || (position_i > cnt_pos)) begin
                res_status = ST_BADPOS;
              end else begin
                ctl.del_en = 1'b1;
                ctl.slot   = position_i - PosW'(1);
                count_d    = count_q - CntW'(1);
              end
            end
            OP_SEARCH: begin
              if (hit) begin
                res_fpos = hit_pos;
              end else begin
                res_status = ST_MISSING;
              end
            end
            OP_COUNT: begin
              res_status = ST_OK;
            end
            OP_DUMP: begin
              if (list_empty) begin
                res_status = ST_EMPTY;
              end else begin
                res_load   = 1'b0;
                dump_idx_d = '0;
              end
            end
            default: begin
              res_status = ST_OK;
            end
          endcase
        end
      end
      S_DUMP: begin
        if (load_ok) begin
          res_load   = 1'b1;
          res_fpos   = dump_pos;
          res_value  = cell_value[0];
          res_last   = dump_last;
          ctl.rot_en = 1'b1;
          dump_idx_d = dump_idx_q + CntW'(1);
        end
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  assign out_valid_d = res_load ? 1'b1 : (out_valid_q && out_stall_i);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      dump_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dump_idx_q  <= dump_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      status_q <= res_status;
      fpos_q   <= res_fpos;
      evalue_q <= res_value;
      len_q    <= PosW'(count_d);
      last_q   <= res_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign found_position_o = fpos_q;
  assign entry_value_o    = evalue_q;
  assign length_o         = len_q;
  assign last_o           = last_q;

  // The length never grows beyond the chain.
  `PLEU_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(DEPTH))
  // During a dump the read index stays inside the list.
  `PLEU_ASSERT(a_dump_idx, clk_i, rst_ni, (state_q == S_DUMP) |-> (dump_idx_q < count_q))
  // The final dump result returns the engine to idle.
  `PLEU_ASSERT(a_dump_end, clk_i, rst_ni, (state_q == S_DUMP && res_load && res_last) |=> (state_q == S_IDLE))
  // A successful insert grows the list by one.
  `PLEU_ASSERT(a_ins_grow, clk_i, rst_ni, ctl.ins_en |=> (count_q == $past(count_q) + CntW'(1)))
  // At most one kind of chain movement per cycle.
  `PLEU_ASSERT(a_one_move, clk_i, rst_ni, $onehot0({ctl.ins_en, ctl.del_en, ctl.rot_en}))

endmodule

`default_nettype wire

[tb/sv/tb_positional_list_engine_unit.sv]
`default_nettype none

module tb_positional_list_engine_unit;
  import pleu_pkg::*;

  localparam int unsigned Depth = 16;
  // Opcodes that the block treats like a count.
  localparam logic [2:0] OpSpareLo = 3'd5;
  localparam logic [2:0] OpSpareHi = 3'd7;
  localparam int HalfPeriod = 4;
  localparam int HoldCycles = 100;
  localparam int IdleLimit = 1000;
  localparam int SettleCycles = 20;
  localparam int MaxReports = 10;
  localparam int RandomItems = 480;

  typedef struct packed {
    logic [2:0]       status;
    logic [PosW-1:0]  fpos;
    logic [DataW-1:0] value;
    logic [PosW-1:0]  len;
    logic             last;
  } list_result_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [2:0]              opcode_i = OP_COUNT;
  logic [PosW-1:0]         position_i = '0;
  logic signed [DataW-1:0] item_value_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [2:0]              status_o;
  logic [PosW-1:0]         found_position_o;
  logic signed [DataW-1:0] entry_value_o;
  logic [PosW-1:0]         length_o;
  logic                    last_o;

  // Shadow copy of the list and the results still owed by the block.
  logic signed [DataW-1:0] shadow_list[$];
  list_result_t            pending_results[$];

  int  mismatches = 0;
  int  items_sent = 0;
  int  results_checked = 0;
  int  full_refusals = 0;
  int  longest_list = 0;
  int  burst_left = 0;
  int  idle_cycles = 0;
  bit  hold_req = 1'b0;

  positional_list_engine_unit #(
    .DEPTH(Depth)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .position_i      (position_i),
    .item_value_i    (item_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .found_position_o(found_position_o),
    .entry_value_o   (entry_value_o),
    .length_o        (length_o),
    .last_o          (last_o)
  );

  // Free-running clock.
  initial begin
    forever #HalfPeriod clk_i = ~clk_i;
  end

  // Queues one expected result; the length is taken after the edit.
  task automatic owe_result(input logic [2:0] status, input int fpos,
                            input logic signed [DataW-1:0] value, input bit last);
    list_result_t r;
    r.status = status;
    r.fpos   = PosW'(fpos);
    r.value  = value;
    r.len    = PosW'(shadow_list.size());
    r.last   = last;
    pending_results.push_back(r);
  endtask

  // Applies one accepted operation to the shadow list and queues its results.
  task automatic apply_list_op(input logic [2:0] op, input logic [PosW-1:0] pos,
                               input logic signed [DataW-1:0] val);
    int n;
    int slot;
    int hit;
    n = shadow_list.size();
    case (op)
      OP_INSERT: begin
        if (n >= Depth) begin
          full_refusals++;
          owe_result(ST_FULL, 0, '0, 1'b1);
        end else if (n == 0) begin
          shadow_list.push_back(val);
          owe_result(ST_OK, 0, '0, 1'b1);
        end else if (pos == 0) begin
          owe_result(ST_BADPOS, 0, '0, 1'b1);
        end else begin
          slot = (pos > n) ? n : int'(pos) - 1;
          shadow_list.insert(slot, val);
          owe_result(ST_OK, 0, '0, 1'b1);
        end
      end
      OP_DELETE: begin
        if (n == 0) begin
          owe_result(ST_EMPTY, 0, '0, 1'b1);
        end else if (pos == 0 || pos > n) begin
          owe_result(ST_BADPOS, 0, '0, 1'b1);
        end else begin
          shadow_list.delete(int'(pos) - 1);
          owe_result(ST_OK, 0, '0, 1'b1);
        end
      end
      OP_SEARCH: begin
        hit = 0;
        for (int i = 0; i < n && hit == 0; i++) begin
          if (shadow_list[i] == val) hit = i + 1;
        end
        if (hit != 0) owe_result(ST_OK, hit, '0, 1'b1);
        else owe_result(ST_MISSING, 0, '0, 1'b1);
      end
      OP_DUMP: begin
        if (n == 0) begin
          owe_result(ST_EMPTY, 0, '0, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) begin
            owe_result(ST_OK, i + 1, shadow_list[i], i == n - 1);
          end
        end
      end
      default: begin
        // Count and the spare opcodes report the length only.
        owe_result(ST_OK, 0, '0, 1'b1);
      end
    endcase
    if (shadow_list.size() > longest_list) longest_list = shadow_list.size();
  endtask

  // Offers one item, idling between bursts, and predicts it once transferred.
  task automatic send_item(input logic [2:0] op, input logic [PosW-1:0] pos,
                           input logic signed [DataW-1:0] val);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    position_i   <= pos;
    item_value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    apply_list_op(op, pos, val);
  endtask

  // Values lean on the extremes and on a small pool so that duplicates occur.
  function automatic logic signed [DataW-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $signed(DataW'($urandom_range(0, 7))) - 4;
      3: return -1;
      default: return $signed($urandom);
    endcase
  endfunction

  // Positions are mostly in range, sometimes zero or past the end.
  function automatic logic [PosW-1:0] pick_position(input int n);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return PosW'($urandom_range(n + 1, 64));
      2: return PosW'(64);
      default: return PosW'($urandom_range(1, n + 1));
    endcase
  endfunction

  // Empty list: every operation on it, and an insert at position zero.
  task automatic test_empty_list();
    send_item(OP_DELETE, 7'd5, 32'sd0);
    send_item(OP_DUMP, 7'd0, 32'sd0);
    send_item(OP_SEARCH, 7'd0, 32'sd0);
    send_item(OP_COUNT, 7'd0, 32'sd0);
    send_item(OP_INSERT, 7'd0, 32'sh7fff_ffff);
  endtask

  // Edits at the front, middle and end, bad positions, search, count, dump and the spare opcodes.
  task automatic test_edits();
    send_item(OP_INSERT, 7'd0, 32'sd9);
    send_item(OP_INSERT, 7'd64, 32'sh8000_0000);
    send_item(OP_INSERT, 7'd1, -32'sd1);
    send_item(OP_INSERT, 7'd2, 32'sd0);
    send_item(OP_INSERT, 7'd3, -32'sd1);
    send_item(OP_SEARCH, 7'd0, -32'sd1);
    send_item(OP_SEARCH, 7'd0, 32'sd12345);
    send_item(OP_DELETE, 7'd0, 32'sd0);
    send_item(OP_DELETE, 7'd64, 32'sd0);
    send_item(OP_DELETE, PosW'(shadow_list.size() + 1), 32'sd0);
    send_item(OP_DELETE, 7'd2, 32'sd0);
    send_item(OP_COUNT, 7'd0, 32'sd0);
    send_item(OP_DUMP, 7'd0, 32'sd0);
    for (int op = OpSpareLo; op <= OpSpareHi; op++) begin
      send_item(3'(op), 7'd1, 32'sd1);
    end
  endtask

  // The receiver holds off while items keep coming, so the input backs up.
  task automatic test_backpressure();
    hold_req = 1'b1;
    burst_left = 30;
    send_item(OP_INSERT, 7'd1, 32'sd11);
    send_item(OP_DUMP, 7'd0, 32'sd0);
    send_item(OP_SEARCH, 7'd0, 32'sd11);
    send_item(OP_INSERT, 7'd64, 32'sd12);
    send_item(OP_COUNT, 7'd0, 32'sd0);
    send_item(OP_DUMP, 7'd0, 32'sd0);
    send_item(OP_DELETE, 7'd1, 32'sd0);
  endtask

  // Random traffic that swings the list between empty and full.
  task automatic test_random_traffic(input int n_items);
    bit grow;
    int n;
    int r;
    logic [2:0] op;
    logic signed [DataW-1:0] val;
    grow = 1'b1;
    for (int k = 0; k < n_items; k++) begin
      n = shadow_list.size();
      if (n == Depth) grow = 1'b0;
      else if (n == 0) grow = 1'b1;
      else if ($urandom_range(0, 49) == 0) grow = !grow;
      r = $urandom_range(0, 99);
      if (r < (grow ? 55 : 15)) op = OP_INSERT;
      else if (r < 65) op = OP_DELETE;
      else if (r < 80) op = OP_SEARCH;
      else if (r < 86) op = OP_COUNT;
      else if (r < 96) op = OP_DUMP;
      else op = 3'($urandom_range(OpSpareLo, OpSpareHi));
      if (op == OP_SEARCH && n > 0 && $urandom_range(0, 1) == 1) begin
        val = shadow_list[$urandom_range(0, n - 1)];
      end else begin
        val = pick_value();
      end
      send_item(op, pick_position(n), val);
    end
  endtask

  // Receiver stall pattern: switches among four randomly chosen stall modes.
  initial begin : rx_stall_gen
    int mode;
    int left;
    int phase;
    mode = 0;
    left = 0;
    phase = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles - 1) @(posedge clk_i);
        @(posedge clk_i);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 80);
      end
      left--;
      phase++;
      case (mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= $urandom_range(0, 1);
        default: out_stall_i <= (phase % 5 >= 3);
      endcase
    end
  end

  // Compares each transferred result with the oldest one owed.
  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("Unexpected result: status %0d pos %0d value %0d len %0d last %0d",
                   status_o, found_position_o, entry_value_o, length_o, last_o);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status || found_position_o !== want.fpos ||
            entry_value_o !== $signed(want.value) || length_o !== want.len ||
            last_o !== want.last) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display({"Result mismatch: expected status %0d pos %0d value %0d len %0d",
                      " last %0d, got status %0d pos %0d value %0d len %0d last %0d"},
                     want.status, want.fpos, $signed(want.value), want.len, want.last,
                     status_o, found_position_o, entry_value_o, length_o, last_o);
        end
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout: no transfer for %0d cycles", IdleLimit);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_edits();
    test_backpressure();
    test_random_traffic(RandomItems);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    $display("Run covered %0d items in and %0d results out; the list reached %0d entries.",
             items_sent, results_checked, longest_list);
    $display("Inserts refused on a full list: %0d; mismatches: %0d.",
             full_refusals, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
+incdir+rtl/core
rtl/core/pleu_pkg.sv
rtl/core/pleu_cell.sv
rtl/core/positional_list_engine_unit.sv
tb/sv/tb_positional_list_engine_unit.sv
